[design/msp_pkg.sv]
// Shared types and codes for the multi-sensor position calibrator.
// No dependencies; imported by the store and the top level.
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

  // operation codes carried by the mode field
  localparam logic [1:0] OP_MEASURE = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_SET     = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // sensor codes
  localparam logic [1:0] SRC_HALL   = 2'd0;
  localparam logic [1:0] SRC_ANALOG = 2'd1;
  localparam logic [1:0] SRC_ACCEL  = 2'd2;
  localparam logic [1:0] SRC_NONE   = 2'd3;

  // source_mode values
  localparam logic [1:0] SMODE_ACCEL   = 2'd0;
  localparam logic [1:0] SMODE_ENCODER = 2'd1;
  localparam logic [1:0] SMODE_AUTO    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SOURCE_MODE     = 3'd0;
  localparam logic [2:0] REG_SENSORS_PRESENT = 3'd1;
  localparam logic [2:0] REG_HALL_MIN_SPAN   = 3'd2;
  localparam logic [2:0] REG_ANALOG_MIN_SPAN = 3'd3;
  localparam logic [2:0] REG_ACCEL_MIN_SPAN  = 3'd4;

  // write command into the calibration point store
  typedef struct packed {
    logic [1:0] idx;
    logic       wr_closed;
    logic       wr_open;
    logic       set_cal;
    logic       clr_cal;
    logic       clr_pts;
    logic       clr_uncal;
  } cmd_t;

  // per-source marks read back from the store
  typedef struct packed {
    logic [2:0] cvalid;
    logic [2:0] ovalid;
    logic [2:0] cal;
  } status_t;

endpackage

`default_nettype wire

[design/msp_alu.sv]
// Shared subtract unit of the calibrator: one signed difference per cycle.
// Used by the sequencer for spans, magnitudes, compares and divide steps.
`timescale 1ns / 1ps
`default_nettype none

module msp_alu #(
  parameter int W = 32
) (
  input  wire logic signed [W-1:0] a,
  input  wire logic signed [W-1:0] b,
  output logic signed [W-1:0]      diff,
  output logic                     neg
);

  assign diff = a - b;
  // operands never come close to the range limit, so the sign bit is a < b
  assign neg  = diff[W-1];

endmodule

`default_nettype wire

[design/msp_store.sv]
// Calibration point store: closed/open points, valid marks, calibrated flags.
// Depends on msp_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module msp_store
  import msp_pkg::*;
#(
  parameter int PW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  input  wire logic signed [PW-1:0] closed_wd,
  input  wire logic signed [PW-1:0] open_wd,
  input  wire logic [1:0]           rd_idx,
  output logic signed [PW-1:0]      rd_closed,
  output logic signed [PW-1:0]      rd_open,
  output status_t                   status
);

  logic signed [PW-1:0] closed_r [3];
  logic signed [PW-1:0] open_r [3];
  logic [2:0] cval_r, cval_nxt;
  logic [2:0] oval_r, oval_nxt;
  logic [2:0] cal_r, cal_nxt;

  // point values only matter once marked valid, so they carry no reset
  always_ff @(posedge clk) begin
    if (cmd.wr_closed) closed_r[cmd.idx] <= closed_wd;
    if (cmd.wr_open) open_r[cmd.idx] <= open_wd;
  end

  always_comb begin
    cval_nxt = cval_r;
    oval_nxt = oval_r;
    cal_nxt  = cal_r;
    if (cmd.wr_closed) cval_nxt[cmd.idx] = 1'b1;
    if (cmd.wr_open) oval_nxt[cmd.idx] = 1'b1;
    if (cmd.clr_pts) begin
      cval_nxt[cmd.idx] = 1'b0;
      oval_nxt[cmd.idx] = 1'b0;
    end
    if (cmd.set_cal) cal_nxt[cmd.idx] = 1'b1;
    if (cmd.clr_cal) cal_nxt[cmd.idx] = 1'b0;
    if (cmd.clr_uncal) begin
      cval_nxt = cval_r & cal_r;
      oval_nxt = oval_r & cal_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cval_r <= '0;
      oval_r <= '0;
      cal_r  <= '0;
    end else begin
      cval_r <= cval_nxt;
      oval_r <= oval_nxt;
      cal_r  <= cal_nxt;
    end
  end

  assign rd_closed     = closed_r[rd_idx];
  assign rd_open       = open_r[rd_idx];
  assign status.cvalid = cval_r;
  assign status.ovalid = oval_r;
  assign status.cal    = cal_r;

endmodule

`default_nettype wire

[design/multi_sensor_position_calibrator_core.sv]
// Multi-sensor position calibrator, top level: config port, sequencer, datapath.
// Measure: the opening is set by the restoring divider, one quotient bit per cycle
// on the shared subtract unit. Capture fits each eligible source in turn. One item
// at a time; a new item is taken in the cycle after the previous one finishes.
// Reset (rst_n low, synchronous) clears marks, flags and config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module multi_sensor_position_calibrator_core
  import msp_pkg::*;
#(
  parameter int RAW_WIDTH     = 16,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_mode,
  input  wire logic [1:0]                  in_source,
  input  wire logic                        in_closed_point_flag,
  input  wire logic signed [RAW_WIDTH-1:0] in_hall_raw,
  input  wire logic signed [RAW_WIDTH-1:0] in_analog_raw,
  input  wire logic signed [RAW_WIDTH-1:0] in_accel_raw,
  input  wire logic                        in_accel_available,
  input  wire logic                        in_operation_blocked,
  input  wire logic signed [15:0]          in_cal_closed,
  input  wire logic signed [15:0]          in_cal_open,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_active_source,
  output logic [$clog2((100 << FRACTION_BITS) + 1)-1:0] out_opening,
  output logic                             out_opening_valid,
  output logic                             out_accepted,
  output logic                             out_any_calibrated,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [4:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int PW     = (RAW_WIDTH > 16) ? RAW_WIDTH : 16;
  localparam int FULL   = 100 << FRACTION_BITS;
  localparam int OPEN_W = $clog2(FULL + 1);
  localparam int DV_W   = PW + OPEN_W;
  localparam int W      = DV_W + 1;
  localparam int CNT_W  = $clog2(OPEN_W);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CAP   = 4'd1;
  localparam logic [3:0] S_DIFF  = 4'd2;
  localparam logic [3:0] S_ABS   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_NUM   = 4'd5;
  localparam logic [3:0] S_NABS  = 4'd6;
  localparam logic [3:0] S_CLAMP = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // ---------------- configuration ----------------
  logic [1:0]  smode_r;
  logic [2:0]  present_r;
  logic [15:0] hall_min_r, analog_min_r, accel_min_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smode_r      <= SMODE_AUTO;
      present_r    <= 3'd0;
      hall_min_r   <= 16'd10;
      analog_min_r <= 16'd124;
      accel_min_r  <= 16'd1671;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_SOURCE_MODE:     smode_r      <= pwdata[1:0];
        REG_SENSORS_PRESENT: present_r    <= pwdata[2:0];
        REG_HALL_MIN_SPAN:   hall_min_r   <= pwdata[15:0];
        REG_ANALOG_MIN_SPAN: analog_min_r <= pwdata[15:0];
        REG_ACCEL_MIN_SPAN:  accel_min_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SOURCE_MODE:     prdata = {30'd0, smode_r};
      REG_SENSORS_PRESENT: prdata = {29'd0, present_r};
      REG_HALL_MIN_SPAN:   prdata = {16'd0, hall_min_r};
      REG_ANALOG_MIN_SPAN: prdata = {16'd0, analog_min_r};
      REG_ACCEL_MIN_SPAN:  prdata = {16'd0, accel_min_r};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- item registers ----------------
  logic [3:0]                  state_r, state_nxt;
  logic [1:0]                  op_r;
  logic [1:0]                  idx_r, idx_nxt;
  logic                        cflag_r, avail_r;
  logic signed [RAW_WIDTH-1:0] hall_r, analog_r, accel_r;
  logic signed [15:0]          cal_c_r, cal_o_r;

  logic signed [PW:0]   den_r, den_nxt;
  logic signed [PW:0]   num_r, num_nxt;
  logic [PW-1:0]        span_r, span_nxt;
  logic [PW-1:0]        an_r, an_nxt;
  logic [DV_W-1:0]      rem_r, rem_nxt;
  logic [DV_W-1:0]      dsh_r, dsh_nxt;
  logic [OPEN_W-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [OPEN_W-1:0]    res_open_r, res_open_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_acc_r, res_acc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           o_src_r;
  logic [OPEN_W-1:0]    o_open_r;
  logic                 o_valid_r, o_acc_r, o_any_r;
  logic                 out_load;

  logic                 in_fire;
  cmd_t                 cmd;
  status_t              status;
  logic signed [PW-1:0] rd_closed, rd_open;
  logic signed [PW-1:0] closed_wd, open_wd;
  logic signed [W-1:0]  alu_a, alu_b, alu_diff;
  logic                 alu_neg;
  logic signed [PW-1:0] raw_sel;
  logic [15:0]          min_sel;
  logic [1:0]           resolved;
  logic                 eligible;
  logic [OPEN_W-1:0]    q_step;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // active source choice from the current flags
  function automatic logic [1:0] resolve_src(input logic [1:0] smode,
                                             input logic [2:0] present,
                                             input logic [2:0] cal,
                                             input logic       avail,
                                             input logic       blocked);
    logic [1:0] ha;
    logic [1:0] ac;
    logic [1:0] res;
    ha = SRC_NONE;
    if (present[0] && cal[0]) ha = SRC_HALL;
    else if (present[1] && cal[1]) ha = SRC_ANALOG;
    ac = (present[2] && avail && cal[2]) ? SRC_ACCEL : SRC_NONE;
    if (smode == SMODE_ACCEL) res = ac;
    else if (smode == SMODE_ENCODER) res = blocked ? SRC_NONE : ((ha != SRC_NONE) ? ha : ac);
    else res = (ac != SRC_NONE) ? ac : ha;
    return res;
  endfunction

  assign resolved = resolve_src(smode_r, present_r, status.cal,
                                in_accel_available, in_operation_blocked);

  always_comb begin
    case (idx_r)
      SRC_HALL:   raw_sel = PW'(hall_r);
      SRC_ANALOG: raw_sel = PW'(analog_r);
      default:    raw_sel = PW'(accel_r);
    endcase
    case (idx_r)
      SRC_HALL:   min_sel = hall_min_r;
      SRC_ANALOG: min_sel = analog_min_r;
      default:    min_sel = accel_min_r;
    endcase
  end

  assign eligible = present_r[idx_r] && !status.cal[idx_r] && ((idx_r != SRC_ACCEL) || avail_r);

  // operand selection for the shared subtract unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      S_DIFF: begin
        if (op_r == OP_SET) begin
          alu_a = W'(cal_o_r);
          alu_b = W'(cal_c_r);
        end else begin
          alu_a = W'(rd_open);
          alu_b = W'(rd_closed);
        end
      end
      S_ABS: begin
        if (den_r[PW]) alu_b = W'(den_r);
        else alu_a = W'(den_r);
      end
      S_CMP: begin
        alu_a = W'(span_r);
        alu_b = W'(min_sel);
      end
      S_NUM: begin
        alu_a = W'(raw_sel);
        alu_b = W'(rd_closed);
      end
      S_NABS: begin
        if (num_r[PW]) alu_b = W'(num_r);
        else alu_a = W'(num_r);
      end
      S_CLAMP: begin
        alu_a = W'(an_r);
        alu_b = W'(span_r);
      end
      S_DIV: begin
        alu_a = W'(rem_r);
        alu_b = W'(dsh_r);
      end
      default: ;
    endcase
  end

  msp_alu #(.W(W)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .neg  (alu_neg)
  );

  assign q_step   = {q_r[OPEN_W-2:0], !alu_neg};
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    span_nxt      = span_r;
    an_nxt        = an_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    res_open_nxt  = res_open_r;
    res_valid_nxt = res_valid_r;
    res_acc_nxt   = res_acc_r;
    cmd           = '0;
    cmd.idx       = idx_r;
    closed_wd     = raw_sel;
    open_wd       = raw_sel;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_open_nxt  = '0;
          res_valid_nxt = 1'b0;
          res_acc_nxt   = 1'b0;
          unique case (in_mode)
            OP_MEASURE: begin
              idx_nxt   = resolved;
              state_nxt = (resolved == SRC_NONE) ? S_DONE : S_DIFF;
            end
            OP_CAPTURE: begin
              idx_nxt   = SRC_HALL;
              state_nxt = S_CAP;
            end
            OP_SET: begin
              idx_nxt   = in_source;
              state_nxt = (in_source == SRC_NONE) ? S_DONE : S_DIFF;
            end
            default: begin
              cmd.clr_uncal = 1'b1;
              state_nxt     = S_DONE;
            end
          endcase
        end
      end
      S_CAP: begin
        if (eligible) begin
          cmd.wr_closed = cflag_r;
          cmd.wr_open   = !cflag_r;
          state_nxt     = S_DIFF;
        end else if (idx_r == SRC_ACCEL) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_DIFF: begin
        den_nxt   = alu_diff[PW:0];
        state_nxt = S_ABS;
      end
      S_ABS: begin
        span_nxt  = alu_diff[PW-1:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        unique case (op_r)
          OP_MEASURE: begin
            if (!alu_neg && (den_r != '0)) begin
              res_valid_nxt = 1'b1;
              state_nxt     = S_NUM;
            end else begin
              state_nxt = S_DONE;
            end
          end
          OP_CAPTURE: begin
            if (!alu_neg && status.cvalid[idx_r] && status.ovalid[idx_r]) begin
              cmd.set_cal = 1'b1;
              res_acc_nxt = 1'b1;
            end
            if (idx_r == SRC_ACCEL) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + 2'd1;
              state_nxt = S_CAP;
            end
          end
          OP_SET: begin
            closed_wd = PW'(cal_c_r);
            open_wd   = PW'(cal_o_r);
            if (!alu_neg) begin
              cmd.wr_closed = 1'b1;
              cmd.wr_open   = 1'b1;
              cmd.set_cal   = 1'b1;
              res_acc_nxt   = 1'b1;
            end else begin
              cmd.clr_pts = 1'b1;
              cmd.clr_cal = 1'b1;
            end
            state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_NUM: begin
        num_nxt   = alu_diff[PW:0];
        state_nxt = S_NABS;
      end
      S_NABS: begin
        an_nxt = alu_diff[PW-1:0];
        // zero reading offset or opposite direction gives opening zero
        if ((num_r == '0) || (num_r[PW] != den_r[PW])) state_nxt = S_DONE;
        else state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        if (!alu_neg) begin
          // reading at or beyond the open point
          res_open_nxt = OPEN_W'(FULL);
          state_nxt    = S_DONE;
        end else begin
          rem_nxt   = {{OPEN_W{1'b0}}, an_r} * DV_W'(FULL);
          dsh_nxt   = {{OPEN_W{1'b0}}, span_r} << (OPEN_W - 1);
          q_nxt     = '0;
          cnt_nxt   = CNT_W'(OPEN_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!alu_neg) rem_nxt = alu_diff[DV_W-1:0];
        q_nxt   = q_step;
        dsh_nxt = dsh_r >> 1;
        if (cnt_r == '0) begin
          res_open_nxt = q_step;
          state_nxt    = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  msp_store #(.PW(PW)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .closed_wd (closed_wd),
    .open_wd   (open_wd),
    .rd_idx    (idx_r),
    .rd_closed (rd_closed),
    .rd_open   (rd_open),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_mode;
      cflag_r <= in_closed_point_flag;
      avail_r <= in_accel_available;
      hall_r  <= in_hall_raw;
      analog_r <= in_analog_raw;
      accel_r <= in_accel_raw;
      cal_c_r <= in_cal_closed;
      cal_o_r <= in_cal_open;
    end
    idx_r       <= idx_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    span_r      <= span_nxt;
    an_r        <= an_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    res_open_r  <= res_open_nxt;
    res_valid_r <= res_valid_nxt;
    res_acc_r   <= res_acc_nxt;
    if (out_load) begin
      o_src_r   <= (op_r == OP_MEASURE) ? idx_r : SRC_NONE;
      o_open_r  <= res_open_r;
      o_valid_r <= res_valid_r;
      o_acc_r   <= res_acc_r;
      o_any_r   <= |status.cal;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_active_source  = o_src_r;
  assign out_opening        = o_open_r;
  assign out_opening_valid  = o_valid_r;
  assign out_accepted       = o_acc_r;
  assign out_any_calibrated = o_any_r;

endmodule

`default_nettype wire
